// ===== sv/msi_cdv_pkg.sv =====
// Shared types, constants and modular helper functions for the MSI check digit validator.
package msi_cdv_pkg;

   localparam int LuhnBase    = 10;
   localparam int Mod11Base   = 11;
   localparam int WeightCount = 6;
   localparam int WeightFirst = 2;
   localparam int RecipEleven = 93;
   localparam int RecipShift  = 10;

   localparam logic [3:0] Mod11NoCheck = 4'd10;
   localparam logic [1:0] CountMax     = 2'd3;

   typedef struct packed {
      logic [3:0] digit;
      logic       last;
   } req_type;

   typedef struct packed {
      logic mod10_ok;
      logic mod11_ok;
      logic mod10_mod10_ok;
      logic mod11_mod10_ok;
      logic checksum_ok;
   } rsp_type;

   function automatic logic [3:0] mod10_fold(input logic [4:0] x);
      logic [4:0] r;
      r = x;
      if (r >= 5'(2 * LuhnBase)) begin
         r = r - 5'(2 * LuhnBase);
      end else if (r >= 5'(LuhnBase)) begin
         r = r - 5'(LuhnBase);
      end
      return r[3:0];
   endfunction

   // sum of the decimal digits of twice the value
   function automatic logic [3:0] luhn_double(input logic [3:0] d);
      logic [4:0] t;
      logic [1:0] tens;
      t = {d, 1'b0};
      if (t >= 5'(3 * LuhnBase)) begin
         tens = 2'd3;
      end else if (t >= 5'(2 * LuhnBase)) begin
         tens = 2'd2;
      end else if (t >= 5'(LuhnBase)) begin
         tens = 2'd1;
      end else begin
         tens = 2'd0;
      end
      return 4'(5'(tens) + (t - 5'(tens) * 5'(LuhnBase)));
   endfunction

   // reciprocal estimate of the quotient, then one correcting subtract
   function automatic logic [3:0] mod11_fold(input logic [6:0] x);
      logic [13:0] prod;
      logic [3:0]  q;
      logic [6:0]  r;
      prod = 14'(x) * 14'(RecipEleven);
      q    = prod[13:RecipShift];
      r    = x - 7'(q) * 7'(Mod11Base);
      if (r >= 7'(Mod11Base)) begin
         r = r - 7'(Mod11Base);
      end
      return r[3:0];
   endfunction

   function automatic logic [3:0] luhn_check(input logic [3:0] sum);
      return (sum == 4'd0) ? 4'd0 : 4'(LuhnBase) - sum;
   endfunction

   function automatic logic [3:0] mod11_check(input logic [3:0] sum);
      return (sum == 4'd0) ? 4'd0 : 4'(Mod11Base) - sum;
   endfunction

endpackage

// ===== sv/msi_cdv_state.sv =====
// Running Luhn and weighted mod-11 sums, and the check evaluation on the last digit.
module msi_cdv_state
   import msi_cdv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   output rsp_type result
);

   logic [3:0] luhn_dbl_ff, luhn_plain_ff, luhn_prev_ff;
   logic [3:0] luhn_dbl_in, luhn_plain_in;
   logic [3:0] wsum_ff [WeightCount];
   logic [3:0] wsum_in [WeightCount];
   logic [3:0] wsum_prev_ff;
   logic [3:0] prev_digit_ff;
   logic [1:0] count_ff;
   logic [3:0] digit_m11;
   logic [3:0] exp_luhn, exp_luhn_prev, exp_m11, exp_m11_prev;
   logic       len2, len3, k_ok, m10, m11, m1010, m1110;

   assign digit_m11 = (item.digit >= 4'(Mod11Base)) ? item.digit - 4'(Mod11Base) : item.digit;

   always_comb begin
      luhn_dbl_in   = mod10_fold(5'(luhn_plain_ff) + 5'(luhn_double(item.digit)));
      luhn_plain_in = mod10_fold(5'(luhn_dbl_ff) + 5'(item.digit));
      for (int p = 0; p < WeightCount; p++) begin
         wsum_in[p] = mod11_fold(7'(wsum_ff[(p + 1) % WeightCount])
                                 + 7'(digit_m11) * 7'(WeightFirst + p));
      end
   end

   always_comb begin
      len2          = count_ff >= 2'd1;
      len3          = count_ff >= 2'd2;
      exp_luhn      = luhn_check(luhn_dbl_ff);
      exp_luhn_prev = luhn_check(luhn_prev_ff);
      exp_m11       = mod11_check(wsum_ff[0]);
      exp_m11_prev  = mod11_check(wsum_prev_ff);
      k_ok          = exp_luhn == item.digit;
      m10           = len2 && k_ok;
      m11           = len2 && exp_m11 != Mod11NoCheck && exp_m11 == item.digit;
      m1010         = len3 && exp_luhn_prev == prev_digit_ff && k_ok;
      m1110         = len3 && exp_m11_prev != Mod11NoCheck && exp_m11_prev == prev_digit_ff
                      && k_ok;
      result.mod10_ok       = m10;
      result.mod11_ok       = m11;
      result.mod10_mod10_ok = m1010;
      result.mod11_mod10_ok = m1110;
      result.checksum_ok    = m10 || m11 || m1010 || m1110;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && item.last)) begin
         luhn_dbl_ff   <= '0;
         luhn_plain_ff <= '0;
         luhn_prev_ff  <= '0;
         wsum_prev_ff  <= '0;
         prev_digit_ff <= '0;
         count_ff      <= '0;
         for (int p = 0; p < WeightCount; p++) begin
            wsum_ff[p] <= '0;
         end
      end else if (step) begin
         luhn_dbl_ff   <= luhn_dbl_in;
         luhn_plain_ff <= luhn_plain_in;
         luhn_prev_ff  <= luhn_dbl_ff;
         wsum_prev_ff  <= wsum_ff[0];
         prev_digit_ff <= item.digit;
         if (count_ff != CountMax) begin
            count_ff <= count_ff + 2'd1;
         end
         for (int p = 0; p < WeightCount; p++) begin
            wsum_ff[p] <= wsum_in[p];
         end
      end
   end

endmodule

// ===== sv/msi_check_digit_validator.sv =====
// Top level of the MSI check digit validator: input register, state update, result register.
//
//   channel   ports                              direction   payload
//   request   req_valid, req_stall, req_data     in          digit, last
//   response  rsp_valid, rsp_stall, rsp_data     out         five pass flags
//
// One digit per cycle is taken unless a stalled result holds a last digit in the input register.
// The running sums update between the input and result registers; the latter drives the response.
// Reset clears all sums, the digit count and both valid flags.
// A stalled result holds back only a last digit waiting in the input register.
module msi_check_digit_validator
   import msi_cdv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_item_ff;
   rsp_type result;
   logic    out_free, in_move, req_take;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign in_move   = in_valid_ff && (!in_item_ff.last || out_free);
   assign req_stall = in_valid_ff && !in_move;
   assign req_take  = req_valid && !req_stall;

   msi_cdv_state u_state (
      .clock  (clock),
      .reset  (reset),
      .step   (in_move),
      .item   (in_item_ff),
      .result (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (in_move) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (in_move && in_item_ff.last) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_data;
      end
      if (in_move && in_item_ff.last) begin
         out_item_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

endmodule

// ===== tb/msi_cdv_flag_checker.sv =====
// Flag checker for the MSI check digit validator: predicts every result and compares it.
`timescale 1ns / 100ps

module msi_cdv_flag_checker
   import msi_cdv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      mismatch_count,
   output int      results_outstanding
);

   // [0] holds the sum with the rightmost digit doubled, [1] with it plain
   logic [3:0] luhn_cur [2];
   logic [3:0] luhn_old [2];
   logic [3:0] wsum_cur [WeightCount];
   logic [3:0] wsum_old [WeightCount];
   logic [3:0] prior_digit;
   logic [1:0] seen_count;
   rsp_type    expected_flags [$];
   rsp_type    want;

   function automatic logic [3:0] luhn_needed(input logic [3:0] sum);
      return 4'((LuhnBase - sum % LuhnBase) % LuhnBase);
   endfunction

   function automatic logic [3:0] mod11_needed(input logic [3:0] sum);
      return 4'((Mod11Base - sum % Mod11Base) % Mod11Base);
   endfunction

   task automatic clear_state();
      for (int i = 0; i < 2; i++) begin
         luhn_cur[i] = '0;
         luhn_old[i] = '0;
      end
      for (int p = 0; p < WeightCount; p++) begin
         wsum_cur[p] = '0;
         wsum_old[p] = '0;
      end
      prior_digit = '0;
      seen_count  = '0;
   endtask

   task automatic absorb_digit(input req_type item);
      rsp_type     flags;
      logic        len2, len3, luhn_hit;
      logic [3:0]  e11, e11c;
      logic [3:0]  next_luhn [2];
      logic [3:0]  next_wsum [WeightCount];
      int unsigned twice;
      if (item.last) begin
         len2     = seen_count >= 2'd1;
         len3     = seen_count >= 2'd2;
         luhn_hit = luhn_needed(luhn_cur[0]) == item.digit;
         e11      = mod11_needed(wsum_cur[0]);
         e11c     = mod11_needed(wsum_old[0]);
         flags.mod10_ok       = len2 && luhn_hit;
         flags.mod11_ok       = len2 && e11 != Mod11NoCheck && e11 == item.digit;
         flags.mod10_mod10_ok = len3 && luhn_needed(luhn_old[0]) == prior_digit && luhn_hit;
         flags.mod11_mod10_ok = len3 && e11c != Mod11NoCheck && e11c == prior_digit
                                && luhn_hit;
         flags.checksum_ok    = flags.mod10_ok || flags.mod11_ok || flags.mod10_mod10_ok
                                || flags.mod11_mod10_ok;
         expected_flags.push_back(flags);
         clear_state();
      end else begin
         twice = 2 * item.digit;
         next_luhn[0] = 4'((luhn_cur[1] + twice / LuhnBase + twice % LuhnBase) % LuhnBase);
         next_luhn[1] = 4'((luhn_cur[0] + item.digit) % LuhnBase);
         for (int p = 0; p < WeightCount; p++) begin
            next_wsum[p] = 4'((wsum_cur[(p + 1) % WeightCount]
                               + item.digit * (WeightFirst + p)) % Mod11Base);
         end
         for (int i = 0; i < 2; i++) begin
            luhn_old[i] = luhn_cur[i];
            luhn_cur[i] = next_luhn[i];
         end
         for (int p = 0; p < WeightCount; p++) begin
            wsum_old[p] = wsum_cur[p];
            wsum_cur[p] = next_wsum[p];
         end
         prior_digit = item.digit;
         if (seen_count != CountMax) begin
            seen_count = seen_count + 2'd1;
         end
      end
   endtask

   task automatic report_field(input string field, input logic wanted, input logic seen);
      if (wanted !== seen) begin
         $error("%s: expected %0b, got %0b", field, wanted, seen);
         mismatch_count++;
      end
   endtask

   initial begin
      mismatch_count      = 0;
      results_outstanding = 0;
      clear_state();
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            absorb_digit(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_flags.size() == 0) begin
               $error("result transfer with none expected: %b", rsp_data);
               mismatch_count++;
            end else begin
               want = expected_flags.pop_front();
               report_field("mod10_ok", want.mod10_ok, rsp_data.mod10_ok);
               report_field("mod11_ok", want.mod11_ok, rsp_data.mod11_ok);
               report_field("mod10_mod10_ok", want.mod10_mod10_ok, rsp_data.mod10_mod10_ok);
               report_field("mod11_mod10_ok", want.mod11_mod10_ok, rsp_data.mod11_mod10_ok);
               report_field("checksum_ok", want.checksum_ok, rsp_data.checksum_ok);
            end
         end
         results_outstanding = expected_flags.size();
      end
   end

endmodule

// ===== tb/tb_msi_check_digit_validator.sv =====
// Testbench top for the MSI check digit validator: clock, reset, message stimulus and verdict.
`timescale 1ns / 100ps

module tb_msi_check_digit_validator
   import msi_cdv_pkg::*;
;

   localparam int CycleLimit    = 200000;
   localparam int HoldOffCycles = 300;
   localparam int MaxWait       = 18;

   typedef enum {
      MSG_MOD10,
      MSG_MOD11,
      MSG_MOD10_MOD10,
      MSG_MOD11_MOD10,
      MSG_CORRUPT,
      MSG_NOISE
   } msg_kind_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   int      mismatch_count;
   int      results_outstanding;

   bit           no_gaps;
   bit           hold_off_request;
   int           digits_sent;
   logic [3:0]   msg_digits [$];
   msg_kind_type kind;

   msi_check_digit_validator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   msi_cdv_flag_checker flag_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data            (req_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_data            (rsp_data),
      .mismatch_count      (mismatch_count),
      .results_outstanding (results_outstanding)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic logic [3:0] luhn_digit();
      int unsigned acc;
      int unsigned twice;
      bit          doubled;
      acc     = 0;
      doubled = 1'b1;
      for (int i = msg_digits.size() - 1; i >= 0; i--) begin
         twice = 2 * msg_digits[i];
         acc += doubled ? twice / LuhnBase + twice % LuhnBase : msg_digits[i];
         doubled = !doubled;
      end
      return 4'((LuhnBase - acc % LuhnBase) % LuhnBase);
   endfunction

   function automatic logic [3:0] mod11_digit();
      int unsigned acc;
      int unsigned weight;
      acc    = 0;
      weight = WeightFirst;
      for (int i = msg_digits.size() - 1; i >= 0; i--) begin
         acc += msg_digits[i] * weight;
         weight = (weight == WeightFirst + WeightCount - 1) ? WeightFirst : weight + 1;
      end
      return 4'((Mod11Base - acc % Mod11Base) % Mod11Base);
   endfunction

   task automatic make_message(input msg_kind_type what, input int max_len);
      int len;
      int pos;
      msg_digits.delete();
      len = $urandom_range(0, max_len);
      for (int i = 0; i < len; i++) begin
         msg_digits.push_back(4'($urandom_range(0, 9)));
      end
      case (what)
         MSG_MOD10: begin
            msg_digits.push_back(luhn_digit());
         end
         MSG_MOD11: begin
            msg_digits.push_back(mod11_digit());
         end
         MSG_MOD10_MOD10: begin
            msg_digits.push_back(luhn_digit());
            msg_digits.push_back(luhn_digit());
         end
         MSG_MOD11_MOD10: begin
            msg_digits.push_back(mod11_digit());
            msg_digits.push_back(luhn_digit());
         end
         MSG_CORRUPT: begin
            msg_digits.push_back(luhn_digit());
            pos = $urandom_range(0, msg_digits.size() - 1);
            msg_digits[pos] = 4'((msg_digits[pos] + $urandom_range(1, 9)) % LuhnBase);
         end
         default: begin
            msg_digits.push_back(4'($urandom_range(0, 15)));
            foreach (msg_digits[i]) begin
               msg_digits[i] = 4'($urandom_range(0, 15));
            end
         end
      endcase
   endtask

   task automatic send_digit(input logic [3:0] value, input logic is_last);
      int      gap;
      req_type item;
      gap        = no_gaps ? 0 : $urandom_range(0, MaxWait);
      item.digit = value;
      item.last  = is_last;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      digits_sent++;
   endtask

   task automatic send_message();
      foreach (msg_digits[i]) begin
         send_digit(msg_digits[i], i == msg_digits.size() - 1);
      end
   endtask

   task automatic send_random_message();
      kind = msg_kind_type'($urandom_range(0, MSG_NOISE));
      make_message(kind, ($urandom_range(0, 9) == 0) ? 18 : 6);
      send_message();
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (results_outstanding != 0);
   endtask

   initial begin
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off_request) begin
            rsp_stall <= 1'b1;
            repeat (HoldOffCycles) @(negedge clock);
            hold_off_request = 1'b0;
         end else begin
            int wait_cycles;
            wait_cycles = no_gaps ? 0 : $urandom_range(0, MaxWait);
            if (wait_cycles != 0) begin
               rsp_stall <= 1'b1;
               repeat (wait_cycles) @(negedge clock);
            end
            rsp_stall <= 1'b0;
            do @(posedge clock); while (!(rsp_valid && !rsp_stall));
            @(negedge clock);
         end
      end
   end

   initial begin
      int cycles;
      for (cycles = 0; cycles < CycleLimit; cycles++) begin
         @(posedge clock);
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      no_gaps          = 1'b0;
      hold_off_request = 1'b0;
      digits_sent      = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      msg_digits = '{4'd0};
      send_message();
      msg_digits = '{4'd9};
      send_message();
      msg_digits = '{4'd15};
      send_message();
      msg_digits = '{4'd1, 4'd8};
      send_message();
      msg_digits = '{4'd1, 4'd9};
      send_message();
      msg_digits = '{4'd6, 4'd10};
      send_message();
      msg_digits = '{4'd0, 4'd0, 4'd0};
      send_message();
      msg_digits = '{4'd15, 4'd15, 4'd15};
      send_message();
      make_message(MSG_MOD10_MOD10, 2);
      send_message();
      make_message(MSG_MOD11_MOD10, 2);
      send_message();

      while (digits_sent < 200) begin
         send_random_message();
      end

      no_gaps = 1'b1;
      while (digits_sent < 320) begin
         send_random_message();
      end

      hold_off_request = 1'b1;
      repeat (40) begin
         kind = msg_kind_type'($urandom_range(0, MSG_MOD11_MOD10));
         make_message(kind, 1);
         send_message();
      end
      no_gaps = 1'b0;
      drain_results();

      while (digits_sent < 520) begin
         send_random_message();
      end

      drain_results();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
